// ===== hw/rtl/rhvp_pkg.sv =====
// Shared types, codes and serial-type sizing for the record header parser.
package rhvp_pkg;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEN  = 2'd1,
    PH_COL  = 2'd2
  } phase_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_COLUMN    = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_MALFORMED = 2'd2
  } status_e;

  localparam int unsigned VarintMaxBytes  = 9;
  localparam int unsigned Varint7BitBytes = 8;
  localparam logic [7:0]  VarintDataMask  = 8'h7F;
  localparam int unsigned VarintContBit   = 7;
  localparam int unsigned SerialVarLimit  = 12;

  // Varint accumulator control.
  typedef struct packed {
    logic take;     // shift a byte in this cycle
    logic restart;  // treat the accumulator as empty before the shift
    logic drop;     // clear the accumulator after the shift
  } varint_ctl_t;

  // One result transaction.
  typedef struct packed {
    status_e     status;
    logic [5:0]  column_index;
    logic [31:0] serial_type;
    logic [31:0] body_offset;
    logic [31:0] column_size;
    logic        last;
  } result_t;

  // Byte size of a column from its serial type, low 32 bits.
  function automatic logic [31:0] type_size(input logic [63:0] st);
    logic [32:0] diff;
    logic [31:0] size;
    diff = st[32:0] - 33'(SerialVarLimit);
    if (st[63:4] != '0 || st[3:0] >= 4'(SerialVarLimit)) begin
      size = diff[32:1];
    end else begin
      case (st[3:0]) inside
        4'd1, 4'd2, 4'd3, 4'd4: size = {28'd0, st[3:0]};
        4'd5:                   size = 32'd6;
        4'd6, 4'd7:             size = 32'd8;
        default:                size = 32'd0;
      endcase
    end
    return size;
  endfunction

endpackage

// ===== hw/rtl/rhvp_if.sv =====
// Valid/ready stream interfaces for header bytes and column results.
interface rhvp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  header_byte;
  logic        first;
  logic [31:0] payload_len;

  modport source (output valid, header_byte, first, payload_len, input ready);
  modport sink   (input valid, header_byte, first, payload_len, output ready);
endinterface

interface rhvp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  column_index;
  logic [31:0] serial_type;
  logic [31:0] body_offset;
  logic [31:0] column_size;
  logic        last;

  modport source (output valid, status, column_index, serial_type, body_offset,
                  column_size, last, input ready);
  modport sink   (input valid, status, column_index, serial_type, body_offset,
                  column_size, last, output ready);
endinterface

// ===== hw/rtl/record_header_varint_parser.sv =====
// Record header parser top level: input register, decode, result register.
//
//  channel | dir | payload                                              | ends
//  in_i    | in  | header_byte, first, payload_len                      | valid/ready
//  out_o   | out | status, column_index, serial_type, body_offset,      | valid/ready
//          |     | column_size, last                                    |
//
// One header byte per cycle while no result is held: a byte is captured in the
// input register, then decoded and its result (if any) loaded into the output
// register once that register is free. Reset clears the phase and the varint
// accumulator; the parser waits for a byte with first set. A held result stalls
// decoding; the input register takes a byte when it is empty or when it passes
// its byte on in the same cycle.
module record_header_varint_parser
  import rhvp_pkg::*;
#(
  parameter int unsigned MAX_HEADER_BYTES = 512,
  parameter int unsigned MAX_COLS         = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rhvp_in_if.sink    in_i,
  rhvp_out_if.source out_o
);

  localparam int unsigned HdrW = $clog2(MAX_HEADER_BYTES + 1);
  localparam int unsigned ColW = $clog2(MAX_COLS + 1);

  // Input register
  logic        s1_valid_q, s1_valid_d;
  logic [7:0]  byte_q;
  logic        first_q;
  logic [31:0] plen_q;
  logic        in_acc, s1_adv;

  // Parser state
  phase_e          phase_q, phase_d;
  logic [HdrW-1:0] hdr_len_q, hdr_len_d;
  logic [HdrW-1:0] hdr_pos_q, hdr_pos_d;
  logic [3:0]      lead_lim_q, lead_lim_d;
  logic [31:0]     run_off_q, run_off_d;
  logic [ColW-1:0] col_cnt_q, col_cnt_d;

  // Result register
  logic    out_valid_q, out_valid_d;
  result_t res_q, res_d;
  logic    emit;

  // Varint accumulator
  varint_ctl_t vctl;
  logic [63:0] v_value;
  logic [3:0]  v_count;
  logic        v_done;

  // Decode temporaries
  phase_e          eff_phase;
  logic [HdrW-1:0] hl_eff;
  logic [3:0]      ll_eff;
  logic [HdrW-1:0] pos_inc;
  logic [HdrW-1:0] new_len;
  logic [ColW-1:0] cnt_inc;
  logic [ColW+5:0] idx_ext;
  logic [31:0]     size;
  logic            col_last;

  assign in_acc      = in_i.valid && in_i.ready;
  assign s1_adv      = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || s1_adv;
  assign s1_valid_d  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_adv ? emit : (out_valid_q && !out_o.ready);

  rhvp_varint u_varint (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (vctl),
    .byte_i  (byte_q),
    .value_o (v_value),
    .count_o (v_count),
    .done_o  (v_done)
  );

  always_comb begin
    // Values that a first byte loads before the header length is decoded
    if (first_q) begin
      eff_phase = (plen_q == 32'd0) ? PH_IDLE : PH_LEN;
      hl_eff    = (plen_q < 32'(MAX_HEADER_BYTES)) ? plen_q[HdrW-1:0]
                                                   : HdrW'(MAX_HEADER_BYTES);
      ll_eff    = (plen_q < 32'(VarintMaxBytes)) ? plen_q[3:0] : 4'(VarintMaxBytes);
    end else begin
      eff_phase = phase_q;
      hl_eff    = hdr_len_q;
      ll_eff    = lead_lim_q;
    end

    pos_inc  = hdr_pos_q + HdrW'(1);
    cnt_inc  = col_cnt_q + ColW'(1);
    new_len  = v_value[HdrW-1:0];
    size     = type_size(v_value);
    idx_ext  = {6'd0, col_cnt_q};
    col_last = (pos_inc >= hdr_len_q) || (cnt_inc >= ColW'(MAX_COLS));

    vctl.take    = s1_adv && (eff_phase == PH_LEN || eff_phase == PH_COL);
    vctl.restart = first_q;
    vctl.drop    = v_done;

    phase_d    = phase_q;
    hdr_len_d  = hdr_len_q;
    hdr_pos_d  = hdr_pos_q;
    lead_lim_d = lead_lim_q;
    run_off_d  = run_off_q;
    col_cnt_d  = col_cnt_q;

    emit              = 1'b0;
    res_d             = res_q;
    res_d.status      = ST_MALFORMED;
    res_d.column_index = '0;
    res_d.serial_type = '0;
    res_d.body_offset = '0;
    res_d.column_size = '0;
    res_d.last        = 1'b1;

    if (s1_adv) begin
      if (first_q) begin
        hdr_len_d  = hl_eff;
        lead_lim_d = ll_eff;
        hdr_pos_d  = '0;
        run_off_d  = '0;
        col_cnt_d  = '0;
      end
      case (eff_phase)
        PH_LEN: begin
          phase_d = PH_LEN;
          if (!v_done) begin
            if (v_count >= ll_eff) begin
              emit    = 1'b1;
              phase_d = PH_IDLE;
            end
          end else if (v_value > 64'(hl_eff)) begin
            emit    = 1'b1;
            phase_d = PH_IDLE;
          end else begin
            hdr_len_d = new_len;
            hdr_pos_d = HdrW'(v_count);
            run_off_d = 32'(new_len);
            col_cnt_d = '0;
            if (HdrW'(v_count) >= new_len) begin
              emit         = 1'b1;
              res_d.status = ST_EMPTY;
              phase_d      = PH_IDLE;
            end else begin
              phase_d = PH_COL;
            end
          end
        end
        PH_COL: begin
          hdr_pos_d = pos_inc;
          if (!v_done) begin
            if (pos_inc >= hdr_len_q) begin
              emit    = 1'b1;
              phase_d = PH_IDLE;
            end
          end else begin
            emit               = 1'b1;
            res_d.status       = ST_COLUMN;
            res_d.column_index = idx_ext[5:0];
            res_d.serial_type  = v_value[31:0];
            res_d.body_offset  = run_off_q;
            res_d.column_size  = size;
            res_d.last         = col_last;
            run_off_d          = run_off_q + size;
            col_cnt_d          = cnt_inc;
            if (col_last) begin
              phase_d = PH_IDLE;
            end
          end
        end
        default: begin
          // Empty payload on a first byte; idle bytes are dropped
          phase_d = PH_IDLE;
          if (first_q) begin
            emit         = 1'b1;
            res_d.status = ST_EMPTY;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_IDLE;
      hdr_len_q   <= '0;
      hdr_pos_q   <= '0;
      lead_lim_q  <= '0;
      run_off_q   <= '0;
      col_cnt_q   <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      hdr_len_q   <= hdr_len_d;
      hdr_pos_q   <= hdr_pos_d;
      lead_lim_q  <= lead_lim_d;
      run_off_q   <= run_off_d;
      col_cnt_q   <= col_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q  <= in_i.header_byte;
      first_q <= in_i.first;
      plen_q  <= in_i.payload_len;
    end
    if (s1_adv && emit) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = res_q.status;
  assign out_o.column_index = res_q.column_index;
  assign out_o.serial_type  = res_q.serial_type;
  assign out_o.body_offset  = res_q.body_offset;
  assign out_o.column_size  = res_q.column_size;
  assign out_o.last         = res_q.last;

`ifndef SYNTHESIS
  // A byte in the input register is never overwritten before it is decoded.
  a_no_s1_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s1_valid_q) |-> s1_adv)
    else $error("input register overwritten");

  // Any non-column status closes the record.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status != ST_COLUMN) |-> res_q.last)
    else $error("error status without last");

  // While reading column varints the position stays inside the header.
  a_pos_in_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_COL) |-> (hdr_pos_q < hdr_len_q && col_cnt_q < ColW'(MAX_COLS)))
    else $error("column phase outside header");

  // A final result leaves the parser idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && emit && res_d.last) |=> (phase_q == PH_IDLE))
    else $error("parser not idle after last result");
`endif

endmodule

// ===== hw/rtl/rhvp_varint.sv =====
// Big-endian base-128 varint accumulator, nine bytes at most.
module rhvp_varint
  import rhvp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  varint_ctl_t ctl_i,
  input  logic [7:0]  byte_i,
  output logic [63:0] value_o,
  output logic [3:0]  count_o,
  output logic        done_o
);

  logic [63:0] value_q, value_d, base_value;
  logic [3:0]  count_q, count_d, base_count;

  always_comb begin
    base_value = ctl_i.restart ? 64'd0 : value_q;
    base_count = ctl_i.restart ? 4'd0 : count_q;
    if (base_count < 4'(Varint7BitBytes)) begin
      value_o = {base_value[56:0], byte_i[6:0] & VarintDataMask[6:0]};
    end else begin
      value_o = {base_value[55:0], byte_i};
    end
    count_o = base_count + 4'd1;
    done_o  = (count_o >= 4'(VarintMaxBytes)) || !byte_i[VarintContBit];

    value_d = value_q;
    count_d = count_q;
    if (ctl_i.take) begin
      value_d = ctl_i.drop ? 64'd0 : value_o;
      count_d = ctl_i.drop ? 4'd0 : count_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
      count_q <= '0;
    end else begin
      value_q <= value_d;
      count_q <= count_d;
    end
  end

endmodule
